// ===== sv/urx_pkg.sv =====
`default_nettype none

package urx_pkg;

	localparam int DEF_DATA_BITS = 8;
	localparam int MIN_DATA_BITS = 5;
	localparam int BYTE_W        = 8;
	localparam int CNT_W         = 4;
	localparam int PERIOD_W      = 16;
	localparam int TICK_W        = PERIOD_W + 1;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CLOCKS_PER_BIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DATA_BIT_COUNT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_BIT_COUNT = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_PARITY_ENABLE  = CFG_IDX_W'(3);

	localparam logic [PERIOD_W-1:0] RST_CLOCKS_PER_BIT = PERIOD_W'(868);
	localparam logic [CNT_W-1:0]    RST_DATA_BIT_COUNT = CNT_W'(8);
	localparam logic [1:0]          RST_STOP_BIT_COUNT = 2'd1;

	typedef struct packed {
		logic [PERIOD_W-1:0] clocks_per_bit;
		logic [CNT_W-1:0]    data_bit_count;
		logic [1:0]          stop_bit_count;
		logic                parity_enable;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              parity_error;
	} result_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_DATA   = 4'b0010,
		PH_PARITY = 4'b0100,
		PH_STOP   = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

// ===== sv/urx_frame.sv =====
`default_nettype none

module urx_frame import urx_pkg::*; #(
	parameter int MAX_DATA_BITS = DEF_DATA_BITS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire logic    step,
	input  wire logic    level,
	output logic         res_valid,
	output result_t      res
);

	phase_t                    phase_q, phase_d;
	logic [TICK_W-1:0]         tick_q, tick_d;
	logic [CNT_W-1:0]          rem_q, rem_d, rem_dec;
	logic [MAX_DATA_BITS-1:0]  shift_q, shift_d, shift_in;
	logic [MAX_DATA_BITS:0]    shift_up;
	logic                      acc_q, acc_d;
	logic                      bad_q, bad_d;

	logic [PERIOD_W-1:0]       period;
	logic [TICK_W:0]           period_x3;
	logic [CNT_W-1:0]          n_bits;
	logic [CNT_W-1:0]          n_stop;
	logic [BYTE_W-1:0]         shift_ext;

	assign period    = (cfg.clocks_per_bit == '0) ? PERIOD_W'(1) : cfg.clocks_per_bit;
	assign period_x3 = {2'b00, period} + {1'b0, period, 1'b0};
	assign n_stop    = (cfg.stop_bit_count == 2'd0) ? CNT_W'(1) : CNT_W'(cfg.stop_bit_count);
	assign rem_dec   = (rem_q != '0) ? rem_q - CNT_W'(1) : '0;

	// clamp the data bit count into the supported range
	always_comb begin
		if (cfg.data_bit_count < CNT_W'(MIN_DATA_BITS)) begin
			n_bits = CNT_W'(MIN_DATA_BITS);
		end else if (cfg.data_bit_count > CNT_W'(MAX_DATA_BITS)) begin
			n_bits = CNT_W'(MAX_DATA_BITS);
		end else begin
			n_bits = cfg.data_bit_count;
		end
	end

	// shift right, insert the new bit at the top data position
	assign shift_up = {1'b0, shift_q};
	always_comb begin
		for (int i = 0; i < MAX_DATA_BITS; i++) begin
			shift_in[i] = shift_up[i+1] | (level && (n_bits == CNT_W'(i + 1)));
		end
	end

	assign shift_ext = BYTE_W'(shift_q);
	always_comb begin
		for (int i = 0; i < BYTE_W; i++) begin
			res.rx_byte[i] = shift_ext[i] & (CNT_W'(i) < n_bits);
		end
		res.parity_error = bad_q;
	end

	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		rem_d     = rem_q;
		shift_d   = shift_q;
		acc_d     = acc_q;
		bad_d     = bad_q;
		res_valid = 1'b0;
		if (step) begin
			if (phase_q == PH_IDLE) begin
				if (!level) begin
					phase_d = PH_DATA;
					rem_d   = n_bits;
					shift_d = '0;
					acc_d   = 1'b0;
					bad_d   = 1'b0;
					tick_d  = period_x3[TICK_W:1];
				end
			end else if (tick_q > TICK_W'(1)) begin
				tick_d = tick_q - TICK_W'(1);
			end else begin
				tick_d = TICK_W'(period);
				case (phase_q)
					PH_DATA: begin
						shift_d = shift_in;
						acc_d   = acc_q ^ level;
						rem_d   = rem_dec;
						if (rem_dec == '0) begin
							if (cfg.parity_enable) begin
								phase_d = PH_PARITY;
							end else begin
								phase_d = PH_STOP;
								rem_d   = n_stop;
							end
						end
					end
					PH_PARITY: begin
						bad_d   = level ^ acc_q;
						phase_d = PH_STOP;
						rem_d   = n_stop;
					end
					default: begin
						// a low stop sample is not counted
						if (level) begin
							rem_d = rem_dec;
							if (rem_dec == '0) begin
								phase_d   = PH_IDLE;
								res_valid = 1'b1;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			rem_q   <= '0;
			shift_q <= '0;
			acc_q   <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			rem_q   <= rem_d;
			shift_q <= shift_d;
			acc_q   <= acc_d;
			bad_q   <= bad_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/urx_skid.sv =====
`default_nettype none

module urx_skid import urx_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         in_ready,
	output logic         out_valid,
	output result_t      out_data,
	input  wire logic    out_ready
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop       = out_valid_q & out_ready;
	assign in_ready  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/uart_receiver_top.sv =====
// The line sample that completes a frame puts its result on m_tvalid in the next cycle
// when the output register is free; otherwise the result waits in the skid stage.
// Throughput: one line sample per cycle while s_tready is high; the frame state registers update
// on every accepted sample. s_tready drops only while the output and skid stages both hold a result.
// arst_n clears the frame state to waiting for a start bit, empties the output stages
// and restores the registers to RST_CLOCKS_PER_BIT, 8 data bits, 1 stop bit, no parity.
`default_nettype none

module uart_receiver_top import urx_pkg::*; #(
	parameter int MAX_DATA_BITS = DEF_DATA_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,    // [0] rx_level
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,    // [7:0] rx_byte
	output logic [0:0]                 m_tuser,    // [0] parity_error
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	logic    step;
	logic    res_valid;
	result_t res;
	result_t out_data;

	assign cfg_ready = 1'b1;
	assign step      = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clocks_per_bit <= RST_CLOCKS_PER_BIT;
			cfg_q.data_bit_count <= RST_DATA_BIT_COUNT;
			cfg_q.stop_bit_count <= RST_STOP_BIT_COUNT;
			cfg_q.parity_enable  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CLOCKS_PER_BIT: cfg_q.clocks_per_bit <= cfg_data[PERIOD_W-1:0];
				REG_DATA_BIT_COUNT: cfg_q.data_bit_count <= cfg_data[CNT_W-1:0];
				REG_STOP_BIT_COUNT: cfg_q.stop_bit_count <= cfg_data[1:0];
				REG_PARITY_ENABLE:  cfg_q.parity_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	urx_frame #(
		.MAX_DATA_BITS(MAX_DATA_BITS)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.step     (step),
		.level    (s_tdata[0]),
		.res_valid(res_valid),
		.res      (res)
	);

	urx_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_data (out_data),
		.out_ready(m_tready)
	);

	assign m_tdata    = out_data.rx_byte;
	assign m_tuser[0] = out_data.parity_error;

endmodule

`default_nettype wire

// ===== sv/urx_checker.sv =====
`default_nettype none

module urx_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [0:0] m_tuser
);

	// input stalls only while a result is pending on the output
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("s_tready low with no pending result");

	// a new result follows an accepted transaction
	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid ##1 m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result appeared without an accepted sample");

	// a frame ends on a high stop sample
	a_result_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid ##1 m_tvalid) |-> $past(s_tdata[0]))
		else $error("result produced on a low line sample");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind uart_receiver_top urx_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
